[rtl/core/bounded_xorshift_random_macros.svh]
// ----------------------------------------------------------------------------
// bounded_xorshift_random assertion macros
// shared property shorthands for the bounded random generator
// ----------------------------------------------------------------------------
`ifndef BOUNDED_XORSHIFT_RANDOM_MACROS_SVH
`define BOUNDED_XORSHIFT_RANDOM_MACROS_SVH

// same-cycle implication on clk, off during reset
`define BXR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, off during reset
`define BXR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/bxr_pkg.sv]
// ----------------------------------------------------------------------------
// bxr_pkg
// constants, command codes and shared types of the bounded random generator
// ----------------------------------------------------------------------------
package bxr_pkg;

  localparam int WORD_W  = 64;
  localparam int HALF_W  = 32;
  localparam int BOUND_W = 32;

  localparam logic [WORD_W-1:0] GOLDEN_CONST = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hff51afd7ed558ccd;
  localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'hc4ceb9fe1a85ec53;
  localparam logic [WORD_W-1:0] OUT_MUL      = 64'h2545f4914f6cdd1d;

  localparam int MIX_SHIFT  = 33;
  localparam int XS_SHIFT_A = 12;
  localparam int XS_SHIFT_B = 25;
  localparam int XS_SHIFT_C = 27;

  // configuration port: one 64-bit register at byte address 0
  localparam int          CFG_ADDR_W  = 4;
  localparam int          CFG_IDX_BIT = 3;
  localparam logic        REG_SEED    = 1'b0;

  // datapath operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE     = 4'd0;
  localparam op_t OP_TAKE     = 4'd1;
  localparam op_t OP_MIX_A    = 4'd2;
  localparam op_t OP_MIX_B    = 4'd3;
  localparam op_t OP_MIX_END  = 4'd4;
  localparam op_t OP_DRAW     = 4'd5;
  localparam op_t OP_THR      = 4'd6;
  localparam op_t OP_THR_SAVE = 4'd7;
  localparam op_t OP_RED      = 4'd8;

  // result source
  typedef logic [1:0] sel_t;
  localparam sel_t SEL_RAW = 2'd0;
  localparam sel_t SEL_RED = 2'd1;
  localparam sel_t SEL_BAD = 2'd2;

  typedef struct packed {
    op_t  op;
    logic out_load;
    sel_t out_sel;
    logic out_exh;
  } bxr_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic mode;
    logic bound_zero;
    logic draw_ok;
    logic slot_free;
  } bxr_stat_t;

  function automatic logic [WORD_W-1:0] mix_shift(input logic [WORD_W-1:0] v);
    return v ^ (v >> MIX_SHIFT);
  endfunction

  function automatic logic [WORD_W-1:0] xs_step(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] x;
    x = v ^ (v >> XS_SHIFT_A);
    x = x ^ (x << XS_SHIFT_B);
    x = x ^ (x >> XS_SHIFT_C);
    return x;
  endfunction

endpackage

[rtl/core/bounded_xorshift_random.sv]
// ----------------------------------------------------------------------------
// bounded_xorshift_random
// xorshift64* generator with seed mixing and rejection-sampled bounded draws
// ----------------------------------------------------------------------------
// Each request beat on the in_ stream asks for one number and yields exactly one
// beat on the out_ stream, unless a seed write cuts the request short. In raw
// mode (tuser 0) the state steps by xorshift 12/25/27 and the result is the new
// state times 0x2545f4914f6cdd1d, formed on one shared 32x32 multiplier. In
// bounded mode (tuser 1) the block first computes the rejection threshold
// (2^64 - bound) mod bound, then draws until a draw is at or above it, at most
// MAX_RETRIES draws and then one taken regardless (flagged by retries_used_up),
// and returns the draw mod bound. A bounded request makes two 64-step passes
// through the one-bit-per-cycle remainder unit. A zero bound returns 0 with
// bad_bound set and leaves the state alone. Writing the seed register (byte
// address 0) mixes the seed with a 64-bit finalizer into the state (a zero mix
// becomes the golden-ratio constant); in_tready stays low while the mix runs.
// Reset loads the mix of a zero seed. One result may wait in the output
// register while the next request is accepted.
// ----------------------------------------------------------------------------
`include "bounded_xorshift_random_macros.svh"

module bounded_xorshift_random
  import bxr_pkg::*;
#(
  parameter int MAX_RETRIES = 8,
  parameter int BOUND_BITS  = 32
)(
  input  logic                  clk,
  input  logic                  rst_n,
  // request stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BOUND_W-1:0]    in_tdata,     // [31:0] bound
  input  logic [0:0]            in_tuser,     // [0] mode
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [WORD_W-1:0]     out_tdata,    // [63:0] value
  output logic [1:0]            out_tuser,    // [0] bad_bound, [1] retries_used_up
  // register port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [WORD_W-1:0]     cfg_pwdata,
  output logic [WORD_W-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  // bound bits actually honored, capped at the field width
  localparam int DIV_W = (BOUND_BITS < BOUND_W) ? BOUND_BITS : BOUND_W;

  bxr_cmd_t          cmd;
  bxr_stat_t         stat;
  logic              seed_we;
  logic              seed_hit;
  logic [WORD_W-1:0] seed_q;
  logic              res_bad, res_exh;

  // no wait states on the register port
  assign cfg_pready = 1'b1;
  assign seed_hit   = (cfg_paddr[CFG_IDX_BIT] == REG_SEED);
  assign seed_we    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && seed_hit;
  assign cfg_prdata = seed_hit ? seed_q : '0;

  bxr_ctrl #(.MAX_RETRIES(MAX_RETRIES)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .seed_we  (seed_we),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bxr_dp #(.DIV_W(DIV_W)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .seed_we    (seed_we),
    .seed_wdata (cfg_pwdata),
    .seed_q     (seed_q),
    .req_mode   (in_tuser[0]),
    .req_bound  (in_tdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_value  (out_tdata),
    .out_bad    (res_bad),
    .out_exh    (res_exh)
  );

  assign out_tuser = {res_exh, res_bad};

  // a bad bound never runs the rejection loop
  `BXR_ASSERT_NOW(a_flags_excl, out_tvalid, !(out_tuser[0] && out_tuser[1]), "flags both set")
  // a bad bound always reports zero
  `BXR_ASSERT_NOW(a_bad_zero, out_tvalid && out_tuser[0], out_tdata == '0, "bad bound value")
  // one request at a time
  `BXR_ASSERT_NEXT(a_busy_after_take, in_tvalid && in_tready, !in_tready, "take while busy")
  // seed mixing holds off requests
  `BXR_ASSERT_NEXT(a_mix_blocks, seed_we, !in_tready, "request taken during seed mix")

endmodule

[rtl/core/bxr_mul.sv]
// ----------------------------------------------------------------------------
// bxr_mul
// 64 x 64 multiply modulo 2^64 on one shared 32 x 32 multiplier
// ----------------------------------------------------------------------------
module bxr_mul
  import bxr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] k,
  output logic [WORD_W-1:0] prod,
  output logic              done
);

  logic [WORD_W-1:0] a_r, a_nxt;
  logic [WORD_W-1:0] k_r, k_nxt;
  logic [WORD_W-1:0] pp_r, pp_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [1:0]        step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [HALF_W-1:0] m_a, m_b;

  // step 0: lo*lo, step 1: lo*hi, step 2: hi*lo, step 3: last accumulate
  always_comb begin
    m_a = (step_r == 2'd2) ? a_r[WORD_W-1:HALF_W] : a_r[HALF_W-1:0];
    m_b = (step_r == 2'd1) ? k_r[WORD_W-1:HALF_W] : k_r[HALF_W-1:0];
  end

  always_comb begin
    a_nxt    = a_r;
    k_nxt    = k_r;
    pp_nxt   = pp_r;
    acc_nxt  = acc_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      k_nxt    = k;
      step_nxt = 2'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      pp_nxt   = m_a * m_b;
      step_nxt = step_r + 2'd1;
      case (step_r)
        2'd0:    acc_nxt = acc_r;
        2'd1:    acc_nxt = pp_r;
        default: acc_nxt = acc_r + {pp_r[HALF_W-1:0], {HALF_W{1'b0}}};
      endcase
      if (step_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    k_r   <= k_nxt;
    pp_r  <= pp_nxt;
    acc_r <= acc_nxt;
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

[rtl/core/bxr_div.sv]
// ----------------------------------------------------------------------------
// bxr_div
// restoring remainder unit, 64-bit dividend, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bxr_div
  import bxr_pkg::*;
#(
  parameter int W = 32
)(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [W-1:0]      divisor,
  output logic [W-1:0]      rem,
  output logic              done
);

  localparam int CNT_W = $clog2(WORD_W);

  logic [WORD_W-1:0] q_r, q_nxt;
  logic [W-1:0]      d_r, d_nxt;
  logic [W-1:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [W:0]        part;
  logic [W:0]        diff;

  always_comb begin
    part = {rem_r, q_r[WORD_W-1]};
    diff = part - {1'b0, d_r};
  end

  always_comb begin
    q_nxt    = q_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      d_nxt    = divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = q_r << 1;
      rem_nxt = (part >= {1'b0, d_r}) ? diff[W-1:0] : part[W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign rem  = rem_r;
  assign done = done_r;

endmodule

[rtl/core/bxr_dp.sv]
// ----------------------------------------------------------------------------
// bxr_dp
// datapath: seed and generator state, mixer, draw multiply, remainder, result
// ----------------------------------------------------------------------------
module bxr_dp
  import bxr_pkg::*;
#(
  parameter int DIV_W = 32
)(
  input  logic              clk,
  input  logic              rst_n,
  input  bxr_cmd_t          cmd,
  output bxr_stat_t         stat,
  input  logic              seed_we,
  input  logic [WORD_W-1:0] seed_wdata,
  output logic [WORD_W-1:0] seed_q,
  input  logic              req_mode,
  input  logic [BOUND_W-1:0] req_bound,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_value,
  output logic              out_bad,
  output logic              out_exh
);

  logic [WORD_W-1:0] seed_r;
  logic [WORD_W-1:0] gen_r, gen_nxt;
  logic              mode_r;
  logic [DIV_W-1:0]  bound_r;
  logic [DIV_W-1:0]  thr_r;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_value_r;
  logic              out_bad_r, out_exh_r;

  logic [WORD_W-1:0] xs_next, mix_end;
  logic [WORD_W-1:0] mul_a, mul_k, mul_prod;
  logic              mul_start, mul_done;
  logic [WORD_W-1:0] div_dividend;
  logic [DIV_W-1:0]  div_rem;
  logic              div_start, div_done;

  always_comb begin
    xs_next = xs_step(gen_r);
    mix_end = mix_shift(mul_prod);
  end

  // shared multiplier operand select
  always_comb begin
    mul_start = 1'b0;
    mul_a     = xs_next;
    mul_k     = OUT_MUL;
    case (cmd.op)
      OP_MIX_A: begin
        mul_start = 1'b1;
        mul_a     = mix_shift(seed_r);
        mul_k     = MIX_MUL_A;
      end
      OP_MIX_B: begin
        mul_start = 1'b1;
        mul_a     = mix_end;
        mul_k     = MIX_MUL_B;
      end
      OP_DRAW: begin
        mul_start = 1'b1;
      end
      default: mul_start = 1'b0;
    endcase
  end

  // threshold is (2^64 - bound) mod bound, reduction is draw mod bound
  always_comb begin
    div_start    = (cmd.op == OP_THR) || (cmd.op == OP_RED);
    div_dividend = (cmd.op == OP_THR) ?
                   (WORD_W'(0) - {{(WORD_W-DIV_W){1'b0}}, bound_r}) : mul_prod;
  end

  bxr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .k     (mul_k),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  bxr_div #(.W(DIV_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (bound_r),
    .rem      (div_rem),
    .done     (div_done)
  );

  always_comb begin
    gen_nxt = gen_r;
    case (cmd.op)
      OP_MIX_END: gen_nxt = (mix_end == '0) ? GOLDEN_CONST : mix_end;
      OP_DRAW:    gen_nxt = xs_next;
      default:    gen_nxt = gen_r;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= '0;
      gen_r       <= GOLDEN_CONST;
      out_valid_r <= 1'b0;
    end else begin
      if (seed_we) begin
        seed_r <= seed_wdata;
      end
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_TAKE) begin
      mode_r  <= req_mode;
      bound_r <= req_bound[DIV_W-1:0];
    end
    if (cmd.op == OP_THR_SAVE) begin
      thr_r <= div_rem;
    end
    if (cmd.out_load) begin
      case (cmd.out_sel)
        SEL_RAW: out_value_r <= mul_prod;
        SEL_RED: out_value_r <= {{(WORD_W-DIV_W){1'b0}}, div_rem};
        default: out_value_r <= '0;
      endcase
      out_bad_r <= (cmd.out_sel == SEL_BAD);
      out_exh_r <= cmd.out_exh;
    end
  end

  always_comb begin
    stat.mul_done   = mul_done;
    stat.div_done   = div_done;
    stat.mode       = mode_r;
    stat.bound_zero = (bound_r == '0);
    stat.draw_ok    = (mul_prod >= {{(WORD_W-DIV_W){1'b0}}, thr_r});
    stat.slot_free  = !out_valid_r || out_ready;
  end

  assign seed_q    = seed_r;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_bad   = out_bad_r;
  assign out_exh   = out_exh_r;

endmodule

[rtl/core/bxr_ctrl.sv]
// ----------------------------------------------------------------------------
// bxr_ctrl
// sequencer for seeding, raw draws and rejection-sampled bounded draws
// ----------------------------------------------------------------------------
module bxr_ctrl
  import bxr_pkg::*;
#(
  parameter int MAX_RETRIES = 8
)(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      seed_we,
  input  logic      in_valid,
  output logic      in_ready,
  input  bxr_stat_t stat,
  output bxr_cmd_t  cmd
);

  localparam int CNT_W = $clog2(MAX_RETRIES + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MIXA    = 4'd1;
  localparam logic [3:0] S_WMA     = 4'd2;
  localparam logic [3:0] S_WMB     = 4'd3;
  localparam logic [3:0] S_START   = 4'd4;
  localparam logic [3:0] S_WTHR    = 4'd5;
  localparam logic [3:0] S_DRAW    = 4'd6;
  localparam logic [3:0] S_WDRAW   = 4'd7;
  localparam logic [3:0] S_WRED    = 4'd8;
  localparam logic [3:0] S_OUT_RAW = 4'd9;
  localparam logic [3:0] S_OUT_RED = 4'd10;
  localparam logic [3:0] S_OUT_BAD = 4'd11;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             last_draw;

  assign last_draw = (cnt_r == CNT_W'(MAX_RETRIES));

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    in_ready     = 1'b0;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    cmd.out_sel  = SEL_RAW;
    cmd.out_exh  = 1'b0;
    if (seed_we) begin
      // a new seed restarts the mix from the top
      state_nxt = S_MIXA;
    end else begin
      case (state_r)
        S_IDLE: begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.op    = OP_TAKE;
            cnt_nxt   = '0;
            state_nxt = S_START;
          end
        end
        S_MIXA: begin
          cmd.op    = OP_MIX_A;
          state_nxt = S_WMA;
        end
        S_WMA: begin
          if (stat.mul_done) begin
            cmd.op    = OP_MIX_B;
            state_nxt = S_WMB;
          end
        end
        S_WMB: begin
          if (stat.mul_done) begin
            cmd.op    = OP_MIX_END;
            state_nxt = S_IDLE;
          end
        end
        S_START: begin
          if (!stat.mode) begin
            cmd.op    = OP_DRAW;
            state_nxt = S_WDRAW;
          end else if (stat.bound_zero) begin
            state_nxt = S_OUT_BAD;
          end else begin
            cmd.op    = OP_THR;
            state_nxt = S_WTHR;
          end
        end
        S_WTHR: begin
          if (stat.div_done) begin
            cmd.op    = OP_THR_SAVE;
            state_nxt = S_DRAW;
          end
        end
        S_DRAW: begin
          cmd.op    = OP_DRAW;
          state_nxt = S_WDRAW;
        end
        S_WDRAW: begin
          if (stat.mul_done) begin
            if (!stat.mode) begin
              state_nxt = S_OUT_RAW;
            end else if (last_draw || stat.draw_ok) begin
              cmd.op    = OP_RED;
              state_nxt = S_WRED;
            end else begin
              cnt_nxt   = cnt_r + 1'b1;
              state_nxt = S_DRAW;
            end
          end
        end
        S_WRED: begin
          if (stat.div_done) begin
            state_nxt = S_OUT_RED;
          end
        end
        S_OUT_RAW: begin
          if (stat.slot_free) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = SEL_RAW;
            state_nxt    = S_IDLE;
          end
        end
        S_OUT_RED: begin
          if (stat.slot_free) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = SEL_RED;
            cmd.out_exh  = last_draw;
            state_nxt    = S_IDLE;
          end
        end
        S_OUT_BAD: begin
          if (stat.slot_free) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = SEL_BAD;
            state_nxt    = S_IDLE;
          end
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[tb/bounded_xorshift_random_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_xorshift_random_test
// self-checking bench for the bounded xorshift64* generator
// ----------------------------------------------------------------------------
// Requests go in on the in_ stream and every request gives one result beat on
// the out_ stream. A behavioral copy of the generator state inside the bench
// predicts each result at the moment its request beat is taken, and the
// result beats are checked field by field in arrival order. The run opens with
// a table of directed requests, then goes through phases of random requests.
// Each phase starts from a fresh seed written over the register port while the
// block is idle. Some seeds are built by running the generator backwards, so
// that the first draw is a chosen value: this pins the raw output extremes and
// forces the rejection path of bounded draws. Both sides idle and stall at
// random, with one long receiver hold-off in some phases.
// ----------------------------------------------------------------------------
module bounded_xorshift_random_test
  import bxr_pkg::*;
();

  localparam int RETRY_LIMIT     = 8;
  localparam int N_PHASES        = 12;
  localparam int ITEMS_PER_PHASE = 153;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int SETTLE_CYCLES   = 16;
  localparam int TAIL_CYCLES     = 300;
  localparam int CYCLE_LIMIT     = 3_000_000;

  // generator constants of the bench model
  localparam logic [63:0] GOLDEN   = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] MUL_A    = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] MUL_B    = 64'hc4ce_b9fe_1a85_ec53;
  localparam logic [63:0] STAR_MUL = 64'h2545_f491_4f6c_dd1d;

  // register map: the seed at index 0, index 1 is an unused slot
  localparam logic [CFG_ADDR_W-1:0] SEED_ADDR  = 4'h0;
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = 4'h8;

  // request kinds carried in tuser
  localparam logic MODE_RAW     = 1'b0;
  localparam logic MODE_BOUNDED = 1'b1;

  typedef struct packed {
    logic [63:0] value;
    logic        bad_bound;
    logic        retries_used_up;
  } draw_result_t;

  typedef struct packed {
    logic         mode;
    logic [31:0]  bound;
    logic         forced;   // reseed first so the next draw equals target
    logic [63:0]  target;
    logic         known;    // want holds the typed-in result
    draw_result_t want;
  } request_row_t;

  typedef enum logic [1:0] {
    ALWAYS_READY,
    MOSTLY_READY,
    MOSTLY_STALLED,
    EVERY_THIRD
  } stall_style_t;

  localparam draw_result_t UNTYPED         = '0;
  localparam draw_result_t REDUCED_TO_ZERO = '{64'd0, 1'b0, 1'b0};
  localparam draw_result_t ZERO_BOUND_HIT  = '{64'd0, 1'b1, 1'b0};

  localparam int N_DIRECTED = 20;
  request_row_t directed_rows [0:N_DIRECTED-1] = '{
    // first draws after reset, bound ignored in raw mode
    '{MODE_RAW,     32'h0000_0000, 1'b0, 64'd0, 1'b0, UNTYPED},
    '{MODE_RAW,     32'hffff_ffff, 1'b0, 64'd0, 1'b0, UNTYPED},
    // zero bound flags an error and leaves the state alone
    '{MODE_BOUNDED, 32'h0000_0000, 1'b0, 64'd0, 1'b1, ZERO_BOUND_HIT},
    '{MODE_RAW,     32'h0000_0000, 1'b0, 64'd0, 1'b0, UNTYPED},
    // bound of one always reduces to zero
    '{MODE_BOUNDED, 32'h0000_0001, 1'b0, 64'd0, 1'b1, REDUCED_TO_ZERO},
    '{MODE_BOUNDED, 32'hffff_ffff, 1'b0, 64'd0, 1'b0, UNTYPED},
    '{MODE_BOUNDED, 32'h8000_0000, 1'b0, 64'd0, 1'b0, UNTYPED},
    '{MODE_BOUNDED, 32'h0000_0002, 1'b0, 64'd0, 1'b0, UNTYPED},
    '{MODE_BOUNDED, 32'h0000_0003, 1'b0, 64'd0, 1'b0, UNTYPED},
    '{MODE_BOUNDED, 32'h5555_5555, 1'b0, 64'd0, 1'b0, UNTYPED},
    '{MODE_BOUNDED, 32'haaaa_aaaa, 1'b0, 64'd0, 1'b0, UNTYPED},
    '{MODE_BOUNDED, 32'hc000_0000, 1'b0, 64'd0, 1'b0, UNTYPED},
    // raw output extremes from seeds built backwards
    '{MODE_RAW, 32'h0000_0000, 1'b1, 64'hffff_ffff_ffff_ffff, 1'b1,
      '{64'hffff_ffff_ffff_ffff, 1'b0, 1'b0}},
    '{MODE_RAW, 32'hffff_ffff, 1'b1, 64'd1, 1'b1, '{64'd1, 1'b0, 1'b0}},
    // first draw under the rejection threshold, so a second draw is taken
    '{MODE_BOUNDED, 32'hc000_0000, 1'b1, 64'd1, 1'b0, UNTYPED},
    '{MODE_BOUNDED, 32'h8000_0001, 1'b1, 64'd3, 1'b0, UNTYPED},
    '{MODE_BOUNDED, 32'h0000_0000, 1'b0, 64'd0, 1'b1, ZERO_BOUND_HIT},
    '{MODE_RAW, 32'h0000_0000, 1'b1, 64'h8000_0000_0000_0000, 1'b1,
      '{64'h8000_0000_0000_0000, 1'b0, 1'b0}},
    '{MODE_BOUNDED, 32'h0000_0001, 1'b0, 64'd0, 1'b1, REDUCED_TO_ZERO},
    '{MODE_BOUNDED, 32'h0000_ffff, 1'b0, 64'd0, 1'b0, UNTYPED}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [BOUND_W-1:0]    in_tdata;     // [31:0] bound
  logic [0:0]            in_tuser;     // [0] mode
  logic                  out_tvalid;
  logic                  out_tready;
  logic [WORD_W-1:0]     out_tdata;    // [63:0] value
  logic [1:0]            out_tuser;    // [0] bad_bound, [1] retries_used_up
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [WORD_W-1:0]     cfg_pwdata;
  logic [WORD_W-1:0]     cfg_prdata;
  logic                  cfg_pready;

  // bench copy of the generator
  logic [63:0]  gen_state;
  logic [63:0]  seed_shadow;
  draw_result_t awaited_draws [$];

  int  fail_count;
  int  cycle_count = 0;
  bit  hold_off_pending;
  int  raw_count, bounded_count, zero_bound_count;
  int  rejected_draws, exhausted_count, seed_loads;

  bounded_xorshift_random #(
    .MAX_RETRIES (RETRY_LIMIT),
    .BOUND_BITS  (32)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // generator model
  // ---------------------------------------------------------------------------

  // finalizer mix of the seed; a zero mix is swapped for the golden constant
  function automatic logic [63:0] mix_seed(input logic [63:0] s);
    logic [63:0] v;
    v = s ^ (s >> 33);
    v = v * MUL_A;
    v = v ^ (v >> 33);
    v = v * MUL_B;
    v = v ^ (v >> 33);
    return (v == 64'd0) ? GOLDEN : v;
  endfunction

  // one xorshift step of the state, result is the scrambled new state
  function automatic logic [63:0] step_generator();
    logic [63:0] x;
    x = gen_state;
    x = x ^ (x >> 12);
    x = x ^ (x << 25);
    x = x ^ (x >> 27);
    gen_state = x;
    return x * STAR_MUL;
  endfunction

  // expected result beat of one request, advancing the model state
  function automatic draw_result_t predict_request(input logic mode,
                                                   input logic [31:0] bound);
    draw_result_t r;
    logic [63:0]  wide_bound, threshold, d;
    bit           hit;
    int           tries;
    r = '0;
    hit = 1'b0;
    if (mode == MODE_RAW) begin
      raw_count++;
      r.value = step_generator();
    end else if (bound == 32'd0) begin
      zero_bound_count++;
      r.bad_bound = 1'b1;
    end else begin
      bounded_count++;
      wide_bound = {32'd0, bound};
      threshold = (64'd0 - wide_bound) % wide_bound;
      for (tries = 0; tries < RETRY_LIMIT && !hit; tries++) begin
        d = step_generator();
        if (d >= threshold) begin
          hit = 1'b1;
          r.value = d % wide_bound;
        end else begin
          rejected_draws++;
        end
      end
      if (!hit) begin
        exhausted_count++;
        r.value = step_generator() % wide_bound;
        r.retries_used_up = 1'b1;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // seed construction: run the generator backwards from a wanted first draw
  // ---------------------------------------------------------------------------

  // multiplicative inverse mod 2^64 of an odd constant, newton iteration
  function automatic logic [63:0] odd_inverse(input logic [63:0] a);
    logic [63:0] y;
    y = a;
    repeat (6) y = y * (64'd2 - a * y);
    return y;
  endfunction

  function automatic logic [63:0] seed_for_draw(input logic [63:0] wanted);
    logic [63:0] x, y;
    x = wanted * odd_inverse(STAR_MUL);
    // undo the three xorshifts in reverse order
    y = x;
    repeat (3) y = x ^ (y >> 27);
    x = y;
    repeat (3) y = x ^ (y << 25);
    x = y;
    repeat (6) y = x ^ (y >> 12);
    x = y;
    // x is the state to load, undo the finalizer
    x = x ^ (x >> 33);
    x = x * odd_inverse(MUL_B);
    x = x ^ (x >> 33);
    x = x * odd_inverse(MUL_A);
    return x ^ (x >> 33);
  endfunction

  // ---------------------------------------------------------------------------
  // request side and register port
  // ---------------------------------------------------------------------------

  // offer one request beat and hold valid up; the caller lowers it for gaps
  task automatic issue_request(input logic mode, input logic [31:0] bound,
                               input logic known, input draw_result_t want);
    draw_result_t predicted;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= bound;
    do @(posedge clk); while (!in_tready);
    predicted = predict_request(mode, bound);
    awaited_draws.push_back(known ? want : predicted);
  endtask

  // stop offering and wait until every result beat is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (awaited_draws.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [WORD_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == SEED_ADDR) begin
      seed_shadow = data;
      gen_state   = mix_seed(data);
      seed_loads++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // read back the seed register and compare with the last value written
  task automatic check_seed_reg();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= SEED_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== seed_shadow) begin
      $error("seed readback mismatch: expected %h, got %h", seed_shadow, cfg_prdata);
      fail_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_seed(input logic [63:0] value);
    write_reg(SEED_ADDR, value);
    check_seed_reg();
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver stalls in stretches of one style each; a hold-off request keeps
  // tready low for a long count so the block backs up into its input
  initial begin : receiver
    stall_style_t style;
    int           span, k, tick;
    out_tready <= 1'b0;
    tick = 0;
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        style = stall_style_t'($urandom_range(0, 3));
        span  = $urandom_range(20, 200);
        for (k = 0; k < span && !hold_off_pending; k++) begin
          tick++;
          case (style)
            ALWAYS_READY:   out_tready <= 1'b1;
            MOSTLY_READY:   out_tready <= ($urandom_range(0, 3) != 0);
            MOSTLY_STALLED: out_tready <= ($urandom_range(0, 3) == 0);
            default:        out_tready <= (tick % 3 == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // compare every result beat with the oldest outstanding prediction
  always @(posedge clk) begin : result_check
    draw_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.value           = out_tdata;
      got.bad_bound       = out_tuser[0];
      got.retries_used_up = out_tuser[1];
      if (awaited_draws.size() == 0) begin
        $error("result beat with nothing outstanding: value %h", got.value);
        fail_count++;
      end else begin
        want = awaited_draws.pop_front();
        if (got.value !== want.value) begin
          $error("value mismatch: expected %h, got %h", want.value, got.value);
          fail_count++;
        end
        if (got.bad_bound !== want.bad_bound) begin
          $error("bad_bound mismatch: expected %b, got %b", want.bad_bound,
                 got.bad_bound);
          fail_count++;
        end
        if (got.retries_used_up !== want.retries_used_up) begin
          $error("retries_used_up mismatch: expected %b, got %b",
                 want.retries_used_up, got.retries_used_up);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               awaited_draws.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int          gap, burst_left, sent, phase, pick;
    bit          no_gaps, forced;
    logic [31:0] bound, forced_bound;
    logic [63:0] seed_value, wide_bound, threshold;

    fail_count       = 0;
    hold_off_pending = 1'b0;
    raw_count = 0; bounded_count = 0; zero_bound_count = 0;
    rejected_draws = 0; exhausted_count = 0; seed_loads = 0;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset loads the mix of a zero seed, which is the golden constant
    seed_shadow = 64'd0;
    gen_state   = mix_seed(64'd0);
    check_seed_reg();

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].forced) begin
        drain_results();
        load_seed(seed_for_draw(directed_rows[i].target));
      end
      issue_request(directed_rows[i].mode, directed_rows[i].bound,
                    directed_rows[i].known, directed_rows[i].want);
      gap = $urandom_range(0, 2);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end

    // random phases, each from a fresh seed written while idle
    for (phase = 0; phase < N_PHASES; phase++) begin
      drain_results();
      forced = 1'b0;
      case (phase)
        0:       seed_value = 64'd0;
        1:       seed_value = '1;
        2:       seed_value = 64'h8000_0000_0000_0000;
        3:       seed_value = 64'd1;
        default: seed_value = {$urandom, $urandom};
      endcase
      // now and then start with a draw under the rejection threshold
      if (phase >= 4 && phase % 3 == 0) begin
        forced_bound = $urandom | 32'hc000_0000;
        wide_bound   = {32'd0, forced_bound};
        threshold    = (64'd0 - wide_bound) % wide_bound;
        if (threshold < 64'd2) begin
          forced_bound = 32'hc000_0000;
          threshold    = 64'h4000_0000;
        end
        seed_value = seed_for_draw(64'd1 + {32'd0, $urandom} % (threshold - 64'd1));
        forced = 1'b1;
      end
      // unused register slot, must leave the generator alone
      if (phase == 4) write_reg(SPARE_ADDR, {$urandom, $urandom});
      load_seed(seed_value);

      no_gaps = (phase == 2 || phase == 7 || phase % 4 == 1);
      if (phase == 2 || phase == 7) hold_off_pending = 1'b1;

      sent = 0;
      if (forced) begin
        issue_request(MODE_BOUNDED, forced_bound, 1'b0, UNTYPED);
        sent = 1;
      end
      burst_left = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap = no_gaps ? 0 : $urandom_range(0, 10);
          if (gap != 0) begin
            in_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        burst_left--;
        // bound mix: zero, one, small, powers of two, near the top, wide
        pick = $urandom_range(0, 99);
        if (pick < 6)       bound = 32'd0;
        else if (pick < 10) bound = 32'd1;
        else if (pick < 25) bound = $urandom_range(2, 255);
        else if (pick < 35) bound = 32'd1 << $urandom_range(0, 31);
        else if (pick < 45) bound = 32'hffff_ffff - $urandom_range(0, 15);
        else if (pick < 55) bound = $urandom | 32'h8000_0000;
        else                bound = $urandom;
        issue_request(logic'($urandom_range(0, 1)), bound, 1'b0, UNTYPED);
        sent++;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d raw, %0d bounded and %0d zero-bound requests over %0d seed loads",
             raw_count, bounded_count, zero_bound_count, seed_loads);
    $display("rejected draws %0d, requests that used up all retries %0d",
             rejected_draws, exhausted_count);
    if (fail_count == 0 && awaited_draws.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
